// ===== rtl/uda_pkg.sv =====
// ----------------------------------------------------------------------------
// uda_pkg: shared types and constants for the distance frame averager
// Frame layout, counter widths and the batch record handed from the
// frame checker to the divider.
// ----------------------------------------------------------------------------
package uda_pkg;

   // Frame format
   localparam logic [7:0] HEADER_BYTE = 8'hFF;

   // Saturation limit on accepted frames per batch
   localparam int MAX_FRAMES = 64;

   // Widths
   localparam int COUNT_W = 7;   // holds 0..MAX_FRAMES
   localparam int SUM_W   = 22;  // MAX_FRAMES * 65535 fits
   localparam int AVG_W   = 16;
   localparam int REM_W   = COUNT_W;
   localparam int STEP_W  = $clog2(SUM_W);

   // Divider steps, one quotient bit each
   localparam int DIV_STEPS = SUM_W;

   // Batch record: sum and count of good frames
   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } batch_type;

endpackage

// ===== rtl/uart_distance_frame_averager_core.sv =====
// ----------------------------------------------------------------------------
// uart_distance_frame_averager_core: ultrasonic frame checker and averager
// Checks four-byte distance frames in a received byte stream and reports
// the truncated average distance and frame count once per batch.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries received bytes, one per request; req_tlast marks the last
//   byte of a batch. rsp_* carries one result per batch: average distance
//   and frame count in rsp_tdata, rsp_tuser high when no frame was good.
//   The front end takes one byte per cycle while the queue has room and
//   updates the window, sum and count in that cycle. A batch end pushes a
//   record into a two-entry queue. The back end pops the record, divides
//   the sum by the count with a restoring divider, one quotient bit per
//   cycle, and loads the result into the output register. An empty batch
//   skips the divider.
//   Bytes keep flowing while the divider works; req_tready drops only when
//   both queue entries hold batches not yet popped, which needs two batch
//   ends within the divider time. When rsp_tready is low the result holds
//   in the output register and the divider waits with the next result.
//   Reset clears the window, sum, count, queue and output valid.
// ----------------------------------------------------------------------------
module uart_distance_frame_averager_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // batch_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] average_distance, [22:16] frame_count
   output logic        rsp_tuser    // no_valid_frames
);
   import uda_pkg::*;

   logic      queue_full;
   logic      push_valid;
   batch_type push_batch;
   logic      pop;
   logic      not_empty;
   batch_type head;

   uda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_batch (push_batch)
   );

   uda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_batch (push_batch),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   uda_div u_div (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/uda_front.sv =====
// ----------------------------------------------------------------------------
// uda_front: byte window and frame checker
// Slides a three-byte window over the received bytes, checks header and
// checksum, accumulates distances and emits a batch record on batch end.
// ----------------------------------------------------------------------------
module uda_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic                req_tlast,   // batch_end
   input  logic                queue_full,
   output logic                push_valid,
   output uda_pkg::batch_type  push_batch
);
   import uda_pkg::*;

   logic [7:0]         win_ff [3];
   logic [7:0]         win_in [3];
   logic [1:0]         fill_ff, fill_in;
   logic [1:0]         skip_ff, skip_in;
   logic [SUM_W-1:0]   sum_ff, sum_in, sum_upd;
   logic [COUNT_W-1:0] count_ff, count_in, count_upd;
   logic [7:0]         chk_expect;
   logic               frame_ok;
   logic               accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // Checksum over header, high and low byte, wrapping at 8 bits
   assign chk_expect = HEADER_BYTE + win_ff[1] + win_ff[2];
   assign frame_ok   = (win_ff[0] == HEADER_BYTE) && (chk_expect == req_tdata);

   // Next state for one accepted byte
   always_comb begin
      win_in    = win_ff;
      fill_in   = fill_ff;
      skip_in   = skip_ff;
      sum_upd   = sum_ff;
      count_upd = count_ff;
      if (fill_ff == 2'd3) begin
         if (skip_ff != 2'd0) begin
            skip_in = skip_ff - 2'd1;
         end else if (frame_ok) begin
            if (count_ff < COUNT_W'(MAX_FRAMES)) begin
               sum_upd   = sum_ff + SUM_W'({win_ff[1], win_ff[2]});
               count_upd = count_ff + COUNT_W'(1);
            end
            skip_in = 2'd3;
         end
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = req_tdata;
      end else begin
         case (fill_ff)
            2'd0:    win_in[0] = req_tdata;
            2'd1:    win_in[1] = req_tdata;
            default: win_in[2] = req_tdata;
         endcase
         fill_in = fill_ff + 2'd1;
      end
      sum_in   = sum_upd;
      count_in = count_upd;
      // Batch end clears everything after the record is taken
      if (req_tlast) begin
         win_in[0] = '0;
         win_in[1] = '0;
         win_in[2] = '0;
         fill_in   = '0;
         skip_in   = '0;
         sum_in    = '0;
         count_in  = '0;
      end
   end

   assign push_valid       = accept && req_tlast;
   assign push_batch.sum   = sum_upd;
   assign push_batch.count = count_upd;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[0] <= '0;
         win_ff[1] <= '0;
         win_ff[2] <= '0;
         fill_ff   <= '0;
         skip_ff   <= '0;
         sum_ff    <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         skip_ff  <= skip_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   // Count never passes the limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_FRAMES))
      else $error("frame count above limit");

   // Skipping only happens once the window is full
   a_skip_fill: assert property (@(posedge clock) disable iff (reset)
      skip_ff != 2'd0 |-> fill_ff == 2'd3)
      else $error("skip pending with partial window");

endmodule

// ===== rtl/uda_queue.sv =====
// ----------------------------------------------------------------------------
// uda_queue: two-entry batch record queue
// Decouples the frame checker from the divider so each side stalls alone.
// ----------------------------------------------------------------------------
module uda_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  uda_pkg::batch_type  push_batch,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output uda_pkg::batch_type  head
);
   import uda_pkg::*;

   batch_type  entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] used_ff, used_in;
   logic       do_push, do_pop;

   assign full      = (used_ff == 2'd2);
   assign not_empty = (used_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      used_in = used_ff;
      if (do_push && !do_pop) used_in = used_ff + 2'd1;
      if (!do_push && do_pop) used_in = used_ff - 2'd1;
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_batch;
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         used_ff <= used_in;
      end
   end

   // A record offered while full would be lost
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("batch record pushed into full queue");

endmodule

// ===== rtl/uda_div.sv =====
// ----------------------------------------------------------------------------
// uda_div: batch averager back end
// Pops a batch record, divides sum by count one quotient bit per cycle
// and holds the result in an output register until taken.
// ----------------------------------------------------------------------------
module uda_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  uda_pkg::batch_type  head,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // [15:0] average_distance,
                                            // [22:16] frame_count, [23] zero
   output logic                rsp_tuser    // no_valid_frames
);
   import uda_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic               zero_ff, zero_in;
   logic [REM_W:0]     rem_shift, rem_sub;
   logic               ge;

   logic               out_valid_ff;
   logic [AVG_W-1:0]   avg_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic               flag_ff;
   logic               out_free, load_out;

   assign out_free = !out_valid_ff || rsp_tready;
   assign load_out = (state_ff == ST_DONE) && out_free;
   assign pop      = (state_ff == ST_IDLE) && not_empty;

   // One restoring division step
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_sub   = rem_shift - {1'b0, div_ff};
   assign ge        = (rem_shift >= {1'b0, div_ff});

   // Sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      zero_in  = zero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               quo_in   = head.sum;
               div_in   = head.count;
               rem_in   = '0;
               step_in  = '0;
               zero_in  = (head.count == '0);
               state_in = (head.count == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? rem_sub[REM_W-1:0] : rem_shift[REM_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      zero_ff <= zero_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         avg_ff  <= zero_ff ? '0 : quo_ff[AVG_W-1:0];
         cnt_ff  <= div_ff;
         flag_ff <= zero_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, cnt_ff, avg_ff};
   assign rsp_tuser  = flag_ff;

   // Flagged result carries zero average and zero count
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("empty batch result not zero");

   // Unflagged result has a nonzero count
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[22:16] != '0)
      else $error("result without frames not flagged");

   // Division never starts on a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_ff != '0)
      else $error("division by zero count");

endmodule
